>>> rtl/core/mtcp_pkg.sv
// Package for the MIDI track chunk parser: parse phase type, result kinds,
// status byte codes and the chunk tag lookup.
// No dependencies.
package mtcp_pkg;

    typedef enum logic [3:0] {
        PH_TAG      = 4'd0,
        PH_LEN      = 4'd1,
        PH_DELTA    = 4'd2,
        PH_STATUS   = 4'd3,
        PH_DATA1    = 4'd4,
        PH_DATA2    = 4'd5,
        PH_METATYPE = 4'd6,
        PH_SKIPLEN  = 4'd7,
        PH_SKIP     = 4'd8,
        PH_HALT     = 4'd9
    } phase_t;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_EVENT     = 2'd0;
    localparam kind_t KIND_CHUNK_END = 2'd1;
    localparam kind_t KIND_BAD_TAG   = 2'd2;
    localparam kind_t KIND_NO_STATUS = 2'd3;

    localparam logic [7:0] STATUS_META     = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_CT = 8'hF7;
    localparam logic [7:0] STATUS_SYSTEM   = 8'hF0;

    localparam logic [3:0] CMD_PROGRAM  = 4'hC;
    localparam logic [3:0] CMD_PRESSURE = 4'hD;

    localparam logic [15:0] TRACK_MAX = 16'hFFFF;

    // Expected byte of the "MTrk" chunk tag at a given position.
    function automatic logic [7:0] tag_byte(input logic [1:0] idx);
        logic [7:0] val;
        unique case (idx)
            2'd0: val = 8'h4D;
            2'd1: val = 8'h54;
            2'd2: val = 8'h72;
            2'd3: val = 8'h6B;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // Commands C and D carry a single data byte.
    function automatic logic one_data_byte(input logic [7:0] status);
        return (status[7:4] == CMD_PROGRAM) || (status[7:4] == CMD_PRESSURE);
    endfunction

endpackage

>>> rtl/core/midi_track_chunk_parser_unit.sv
// Top level of the MIDI track chunk parser: byte-wide input channel,
// one registered result channel carrying events, chunk ends and error results.
// Depends on mtcp_pkg.
//
// The whole parse step is a single register stage; a result appears in the cycle
// after the byte is taken. Throughput: one byte per cycle unless m_ready stalls.
// Reset (aresetn low, synchronous): the parser waits for a chunk tag, track count
// is zero and the result register is empty.
module midi_track_chunk_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [27:0] m_delta_ticks,
    output logic [3:0]  m_command,
    output logic [3:0]  m_channel,
    output logic [7:0]  m_first_data,
    output logic [7:0]  m_second_data,
    output logic [15:0] m_track_index,
    output logic        m_end_of_chunk
);

    // Parser state. Each accepted byte advances it by exactly one step.
    mtcp_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] chunk_len_reg, chunk_len_next;
    logic [31:0] consumed_reg, consumed_next;
    logic [27:0] delta_reg, delta_next;
    logic [7:0]  rs_reg, rs_next;
    logic        rs_valid_reg, rs_valid_next;
    logic [27:0] skip_reg, skip_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] track_reg, track_next;

    // Result held for the output side. The input side may load a new result
    // in the same cycle that the old one is taken, so bytes flow every cycle.
    logic        m_valid_reg;
    logic [1:0]  kind_reg;
    logic [27:0] delta_out_reg;
    logic [3:0]  command_reg;
    logic [3:0]  channel_reg;
    logic [7:0]  first_reg;
    logic [7:0]  second_reg;
    logic [15:0] track_out_reg;
    logic        eoc_reg;

    // Result produced by the current byte, if any.
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [27:0] res_delta;
    logic [3:0]  res_command;
    logic [3:0]  res_channel;
    logic [7:0]  res_first;
    logic [7:0]  res_second;
    logic        res_eoc;

    logic        accept;
    logic        event_done;
    logic [31:0] len_shift;
    logic [27:0] skip_shift;
    logic [27:0] skip_dec;
    logic [7:0]  b;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign b       = s_data_byte;

    assign len_shift  = {chunk_len_reg[23:0], b};
    assign skip_shift = {skip_reg[20:0], b[6:0]};
    assign skip_dec   = (skip_reg != 28'd0) ? skip_reg - 28'd1 : skip_reg;

    // One parse step. Phases TAG and LEN read the chunk header, HALT idles after a
    // bad tag; the rest decode the body and count bytes against the chunk length.
    always_comb begin
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        chunk_len_next = chunk_len_reg;
        consumed_next  = consumed_reg;
        delta_next     = delta_reg;
        rs_next        = rs_reg;
        rs_valid_next  = rs_valid_reg;
        skip_next      = skip_reg;
        held_next      = held_reg;
        track_next     = track_reg;

        res_valid   = 1'b0;
        res_kind    = mtcp_pkg::KIND_EVENT;
        res_delta   = '0;
        res_command = '0;
        res_channel = '0;
        res_first   = '0;
        res_second  = '0;
        res_eoc     = 1'b0;
        event_done  = 1'b0;

        unique case (phase_reg)
            mtcp_pkg::PH_TAG: begin
                if (b != mtcp_pkg::tag_byte(hdr_cnt_reg)) begin
                    // A bad tag locks the parser up until reset.
                    res_valid  = 1'b1;
                    res_kind   = mtcp_pkg::KIND_BAD_TAG;
                    res_first  = b;
                    phase_next = mtcp_pkg::PH_HALT;
                end else if (hdr_cnt_reg == 2'd3) begin
                    hdr_cnt_next   = 2'd0;
                    chunk_len_next = '0;
                    phase_next     = mtcp_pkg::PH_LEN;
                end else begin
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                end
            end
            mtcp_pkg::PH_LEN: begin
                chunk_len_next = len_shift;
                if (hdr_cnt_reg == 2'd3) begin
                    hdr_cnt_next  = 2'd0;
                    consumed_next = '0;
                    delta_next    = '0;
                    rs_next       = '0;
                    rs_valid_next = 1'b0;
                    skip_next     = '0;
                    held_next     = '0;
                    phase_next    = mtcp_pkg::PH_DELTA;
                    if (len_shift == 32'd0) begin
                        // An empty chunk ends right at its last length byte.
                        res_valid  = 1'b1;
                        res_kind   = mtcp_pkg::KIND_CHUNK_END;
                        res_eoc    = 1'b1;
                        if (track_reg != mtcp_pkg::TRACK_MAX) begin
                            track_next = track_reg + 16'd1;
                        end
                        phase_next = mtcp_pkg::PH_TAG;
                    end
                end else begin
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                end
            end
            mtcp_pkg::PH_HALT: begin
                phase_next = mtcp_pkg::PH_HALT;
            end
            mtcp_pkg::PH_DELTA,
            mtcp_pkg::PH_STATUS,
            mtcp_pkg::PH_DATA1,
            mtcp_pkg::PH_DATA2,
            mtcp_pkg::PH_METATYPE,
            mtcp_pkg::PH_SKIPLEN,
            mtcp_pkg::PH_SKIP: begin
                consumed_next = consumed_reg + 32'd1;

                unique case (phase_reg)
                    mtcp_pkg::PH_DELTA: begin
                        delta_next = {delta_reg[20:0], b[6:0]};
                        if (!b[7]) begin
                            phase_next = mtcp_pkg::PH_STATUS;
                        end
                    end
                    mtcp_pkg::PH_STATUS: begin
                        if (!b[7]) begin
                            // Data byte: reuse the running status if there is one.
                            if (!rs_valid_reg) begin
                                res_valid  = 1'b1;
                                res_kind   = mtcp_pkg::KIND_NO_STATUS;
                                res_delta  = delta_reg;
                                res_first  = b;
                                event_done = 1'b1;
                            end else if (mtcp_pkg::one_data_byte(rs_reg)) begin
                                res_valid   = 1'b1;
                                res_delta   = delta_reg;
                                res_command = rs_reg[7:4];
                                res_channel = rs_reg[3:0];
                                res_first   = b;
                                event_done  = 1'b1;
                            end else begin
                                held_next  = b;
                                phase_next = mtcp_pkg::PH_DATA2;
                            end
                        end else if (b == mtcp_pkg::STATUS_META) begin
                            phase_next = mtcp_pkg::PH_METATYPE;
                        end else if (b == mtcp_pkg::STATUS_SYSEX ||
                                     b == mtcp_pkg::STATUS_SYSEX_CT) begin
                            skip_next  = '0;
                            phase_next = mtcp_pkg::PH_SKIPLEN;
                        end else begin
                            // Channel statuses set running status; other
                            // system statuses decode once and cancel it.
                            rs_next       = b;
                            rs_valid_next = (b < mtcp_pkg::STATUS_SYSTEM);
                            phase_next    = mtcp_pkg::PH_DATA1;
                        end
                    end
                    mtcp_pkg::PH_DATA1: begin
                        if (mtcp_pkg::one_data_byte(rs_reg)) begin
                            res_valid   = 1'b1;
                            res_delta   = delta_reg;
                            res_command = rs_reg[7:4];
                            res_channel = rs_reg[3:0];
                            res_first   = b;
                            event_done  = 1'b1;
                        end else begin
                            held_next  = b;
                            phase_next = mtcp_pkg::PH_DATA2;
                        end
                    end
                    mtcp_pkg::PH_DATA2: begin
                        res_valid   = 1'b1;
                        res_delta   = delta_reg;
                        res_command = rs_reg[7:4];
                        res_channel = rs_reg[3:0];
                        res_first   = held_reg;
                        res_second  = b;
                        event_done  = 1'b1;
                    end
                    mtcp_pkg::PH_METATYPE: begin
                        skip_next  = '0;
                        phase_next = mtcp_pkg::PH_SKIPLEN;
                    end
                    mtcp_pkg::PH_SKIPLEN: begin
                        skip_next = skip_shift;
                        if (!b[7]) begin
                            if (skip_shift == 28'd0) begin
                                event_done = 1'b1;
                            end else begin
                                phase_next = mtcp_pkg::PH_SKIP;
                            end
                        end
                    end
                    default: begin
                        // Skipping the body of a meta or sysex event.
                        skip_next = skip_dec;
                        if (skip_dec == 28'd0) begin
                            event_done = 1'b1;
                        end
                    end
                endcase

                if (event_done) begin
                    delta_next = '0;
                    phase_next = mtcp_pkg::PH_DELTA;
                end

                // Chunk length used up: close the chunk, dropping any
                // partial event, and flag the result of this byte.
                if (consumed_next >= chunk_len_reg) begin
                    if (!res_valid) begin
                        res_kind = mtcp_pkg::KIND_CHUNK_END;
                    end
                    res_valid = 1'b1;
                    res_eoc   = 1'b1;
                    if (track_reg != mtcp_pkg::TRACK_MAX) begin
                        track_next = track_reg + 16'd1;
                    end
                    hdr_cnt_next = 2'd0;
                    phase_next   = mtcp_pkg::PH_TAG;
                end
            end
            default: begin
                phase_next = mtcp_pkg::PH_HALT;
            end
        endcase
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= mtcp_pkg::PH_TAG;
            hdr_cnt_reg   <= '0;
            chunk_len_reg <= '0;
            consumed_reg  <= '0;
            delta_reg     <= '0;
            rs_reg        <= '0;
            rs_valid_reg  <= 1'b0;
            skip_reg      <= '0;
            held_reg      <= '0;
            track_reg     <= '0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            chunk_len_reg <= chunk_len_next;
            consumed_reg  <= consumed_next;
            delta_reg     <= delta_next;
            rs_reg        <= rs_next;
            rs_valid_reg  <= rs_valid_next;
            skip_reg      <= skip_next;
            held_reg      <= held_next;
            track_reg     <= track_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= accept && res_valid;
        end
    end

    // Result payload; the track index is taken before this byte's update.
    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            kind_reg      <= res_kind;
            delta_out_reg <= res_delta;
            command_reg   <= res_command;
            channel_reg   <= res_channel;
            first_reg     <= res_first;
            second_reg    <= res_second;
            track_out_reg <= track_reg;
            eoc_reg       <= res_eoc;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_delta_ticks  = delta_out_reg;
    assign m_command      = command_reg;
    assign m_channel      = channel_reg;
    assign m_first_data   = first_reg;
    assign m_second_data  = second_reg;
    assign m_track_index  = track_out_reg;
    assign m_end_of_chunk = eoc_reg;

endmodule
